@@ rtl/core/two_pass_otsu_binarizer_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef TWO_PASS_OTSU_BINARIZER_MACROS_SVH
`define TWO_PASS_OTSU_BINARIZER_MACROS_SVH

// Check a property on every rising edge of clk_i while out of reset.
`define TPOB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every rising edge of clk_i while out of reset.
`define TPOB_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

@@ rtl/core/tpob_pkg.sv @@
`default_nettype none
package tpob_pkg;

  localparam int unsigned GRAY_LEVELS = 256;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned COORD_WIDTH = 8;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned MODE_W      = 2;
  localparam logic [PIX_W-1:0] MID_LEVEL    = 8'd128;
  localparam logic [PIX_W-1:0] RESET_THRESH = 8'd128;

  localparam logic [MODE_W-1:0] MODE_SAMPLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPUTE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_COMPUTE,
    OP_CLASSIFY
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [PIX_W-1:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_t;

endpackage
`default_nettype wire

@@ rtl/core/tpob_ram.sv @@
`default_nettype none
module tpob_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/tpob_mul.sv @@
`default_nettype none
module tpob_mul #(
  parameter int unsigned AWidth = 112,
  parameter int unsigned BWidth = 40
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [AWidth-1:0] a_i,
  input  wire logic [BWidth-1:0] b_i,
  output logic                   done_o,
  output logic      [AWidth-1:0] p_o
);

  logic              busy_q;
  logic [AWidth-1:0] a_q;
  logic [BWidth-1:0] b_q;
  logic [AWidth-1:0] acc_q;

  assign done_o = busy_q && (b_q == '0);
  assign p_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tpob_front.sv @@
`default_nettype none
`include "two_pass_otsu_binarizer_macros.svh"
module tpob_front #(
  parameter int unsigned CoordWidth = tpob_pkg::COORD_WIDTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [tpob_pkg::MODE_W-1:0] mode_i,
  input  wire logic [tpob_pkg::PIX_W-1:0]  pixel_value_i,
  input  wire logic [CoordWidth-1:0]       x_pos_i,
  input  wire logic [CoordWidth-1:0]       y_pos_i,
  output tpob_pkg::queue_t                 queue_o,
  input  wire logic                        pop_i
);

  tpob_pkg::cmd_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     count_q;
  logic           keep;
  logic           push;
  tpob_pkg::cmd_t cmd;

  always_comb begin
    cmd.pixel = pixel_value_i;
    cmd.op    = tpob_pkg::OP_SAMPLE;
    keep      = 1'b0;
    case (mode_i)
      tpob_pkg::MODE_SAMPLE: begin
        cmd.op = tpob_pkg::OP_SAMPLE;
        keep   = !x_pos_i[0] && !y_pos_i[0];
      end
      tpob_pkg::MODE_COMPUTE: begin
        cmd.op = tpob_pkg::OP_COMPUTE;
        keep   = 1'b1;
      end
      tpob_pkg::MODE_CLASSIFY: begin
        cmd.op = tpob_pkg::OP_CLASSIFY;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy_o        = (count_q == 2'd2);
  assign push          = start_i && !busy_o && keep;
  assign queue_o.valid = (count_q != 2'd0);
  assign queue_o.cmd   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cmd;
    end
  end

  `TPOB_ASSERT(a_count_bound, count_q <= 2'd2, "queue count out of range")
  `TPOB_ASSERT_IMP(a_pop_nonempty, pop_i, count_q != 2'd0, "pop from empty queue")
  `TPOB_ASSERT_IMP(a_full_no_push, busy_o, !push, "push into full queue")

endmodule
`default_nettype wire

@@ rtl/core/tpob_back.sv @@
`default_nettype none
`include "two_pass_otsu_binarizer_macros.svh"
module tpob_back #(
  parameter int unsigned GrayLevels = tpob_pkg::GRAY_LEVELS,
  parameter int unsigned CountWidth = tpob_pkg::COUNT_WIDTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tpob_pkg::queue_t           queue_i,
  output logic                            pop_o,
  output logic                            result_valid_o,
  output logic                            result_kind_o,
  output logic [tpob_pkg::PIX_W-1:0]      threshold_value_o,
  output logic [tpob_pkg::PIX_W-1:0]      first_threshold_o,
  output logic                            pixel_white_o,
  output logic                            no_samples_o
);

  localparam int unsigned LW = $clog2(GrayLevels);
  localparam int unsigned SW = CountWidth + LW;
  localparam int unsigned DW = 2 * CountWidth + LW;
  localparam int unsigned NW = 2 * CountWidth;
  localparam int unsigned PW = 2 * DW + NW;

  typedef enum logic [3:0] {
    S_IDLE, S_SMP_WR, S_A_RD, S_A_AC, S_A_END, S_B_RD, S_B_AC, S_B_GO, S_B_WT, S_PASS_END
  } state_e;

  typedef enum logic [2:0] {
    M_A, M_B, M_DEN, M_DSQ, M_LHS, M_RHS
  } step_e;

  state_e state_q;
  step_e  step_q;

  logic [CountWidth-1:0]     samp_q;
  logic [7:0]                active_q;
  logic [GrayLevels-1:0]     vld_q;
  logic                      pass_q;
  logic [7:0]                t1_q;
  logic [7:0]                thr_q;
  logic [LW-1:0]             t_q, lo_q, hi_q, rd_addr_q;
  logic                      any_q;
  logic [CountWidth-1:0]     cum_q, fold_val_q, wb_q;
  logic [SW-1:0]             tot_q, sb_q;
  logic                      have_q;
  logic [DW-1:0]             a_q, d_q;
  logic [NW-1:0]             den_q, bn_q;
  logic [2*DW-1:0]           dsq_q, bsq_q;
  logic [PW-1:0]             lhs_q;

  logic                      valid_q, kind_q, white_q, nos_q;
  logic [7:0]                thr_out_q, first_q;

  logic [LW-1:0]             raddr, bin, fold;
  logic [CountWidth-1:0]     rdata, h, cum_incl, work_a, work_b, wb_d;
  logic [SW-1:0]             sb_d;
  logic                      ram_we;
  logic                      mul_start, mul_done;
  logic [PW-1:0]             mul_a, mul_p;
  logic [DW-1:0]             mul_b;
  logic [7:0]                thr_fin, lo_thr;
  logic                      below_t1;

  always_comb begin
    if (32'(queue_i.cmd.pixel) >= GrayLevels) begin
      bin = LW'(GrayLevels - 1);
    end else begin
      bin = LW'(queue_i.cmd.pixel);
    end
    if (32'(t1_q) >= GrayLevels) begin
      fold = LW'(GrayLevels - 1);
    end else begin
      fold = LW'(t1_q);
    end
  end

  assign raddr    = (state_q == S_IDLE) ? bin : t_q;
  assign h        = vld_q[rd_addr_q] ? rdata : '0;
  assign cum_incl = cum_q + h;
  assign below_t1 = 32'(t_q) < 32'(t1_q);
  assign work_a   = !pass_q ? h : ((t_q == fold) ? cum_incl : (below_t1 ? '0 : h));
  assign work_b   = !pass_q ? h : ((t_q == fold) ? fold_val_q : (below_t1 ? '0 : h));
  assign wb_d     = wb_q + work_b;
  assign sb_d     = sb_q + SW'(t_q) * SW'(work_b);
  assign ram_we   = (state_q == S_SMP_WR);
  assign thr_fin  = (thr_q == 8'd0) ? 8'd1 : thr_q;
  assign lo_thr   = (8'(lo_q) < tpob_pkg::MID_LEVEL) ? 8'(lo_q) + 8'd1 : 8'(lo_q);
  assign pop_o    = (state_q == S_IDLE) && queue_i.valid;
  assign mul_start = (state_q == S_B_GO);

  always_comb begin
    mul_a = PW'(sb_q);
    mul_b = DW'(samp_q);
    case (step_q)
      M_A: begin
        mul_a = PW'(sb_q);
        mul_b = DW'(samp_q);
      end
      M_B: begin
        mul_a = PW'(tot_q);
        mul_b = DW'(wb_q);
      end
      M_DEN: begin
        mul_a = PW'(wb_q);
        mul_b = DW'(samp_q - wb_q);
      end
      M_DSQ: begin
        mul_a = PW'(d_q);
        mul_b = d_q;
      end
      M_LHS: begin
        mul_a = PW'(dsq_q);
        mul_b = DW'(bn_q);
      end
      M_RHS: begin
        mul_a = PW'(bsq_q);
        mul_b = DW'(den_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tpob_ram #(
    .Width(CountWidth),
    .Depth(GrayLevels)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(rd_addr_q),
    .wdata_i(h + CountWidth'(1)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  tpob_mul #(
    .AWidth(PW),
    .BWidth(DW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= M_A;
      samp_q   <= '0;
      active_q <= tpob_pkg::RESET_THRESH;
      vld_q    <= '0;
      pass_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= ((state_q == S_IDLE) && queue_i.valid &&
                  (((queue_i.cmd.op == tpob_pkg::OP_COMPUTE) && (samp_q == '0)) ||
                   (queue_i.cmd.op == tpob_pkg::OP_CLASSIFY))) ||
                 ((state_q == S_PASS_END) && pass_q);
      case (state_q)
        S_IDLE: begin
          if (queue_i.valid) begin
            case (queue_i.cmd.op)
              tpob_pkg::OP_SAMPLE: begin
                if (samp_q != '1) begin
                  state_q <= S_SMP_WR;
                end
              end
              tpob_pkg::OP_COMPUTE: begin
                if (samp_q == '0) begin
                  kind_q    <= tpob_pkg::KIND_THRESH;
                  thr_out_q <= active_q;
                  first_q   <= 8'd0;
                  white_q   <= 1'b0;
                  nos_q     <= 1'b1;
                  vld_q     <= '0;
                end else begin
                  pass_q  <= 1'b0;
                  t_q     <= '0;
                  cum_q   <= '0;
                  any_q   <= 1'b0;
                  tot_q   <= '0;
                  state_q <= S_A_RD;
                end
              end
              tpob_pkg::OP_CLASSIFY: begin
                kind_q    <= tpob_pkg::KIND_PIXEL;
                thr_out_q <= active_q;
                first_q   <= 8'd0;
                white_q   <= queue_i.cmd.pixel >= active_q;
                nos_q     <= 1'b0;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_SMP_WR: begin
          vld_q[rd_addr_q] <= 1'b1;
          samp_q           <= samp_q + CountWidth'(1);
          state_q          <= S_IDLE;
        end
        S_A_RD: begin
          state_q <= S_A_AC;
        end
        S_A_AC: begin
          cum_q <= cum_incl;
          tot_q <= tot_q + SW'(t_q) * SW'(work_a);
          if (work_a != '0) begin
            if (!any_q) begin
              lo_q <= t_q;
            end
            hi_q  <= t_q;
            any_q <= 1'b1;
          end
          if (t_q == fold) begin
            fold_val_q <= cum_incl;
          end
          if (t_q == LW'(GrayLevels - 1)) begin
            state_q <= S_A_END;
          end else begin
            t_q     <= t_q + LW'(1);
            state_q <= S_A_RD;
          end
        end
        S_A_END: begin
          if (!any_q) begin
            thr_q   <= 8'd1;
            state_q <= S_PASS_END;
          end else if (lo_q >= hi_q) begin
            thr_q   <= lo_thr;
            state_q <= S_PASS_END;
          end else begin
            t_q     <= lo_q;
            wb_q    <= '0;
            sb_q    <= '0;
            have_q  <= 1'b0;
            thr_q   <= 8'(lo_q);
            state_q <= S_B_RD;
          end
        end
        S_B_RD: begin
          state_q <= S_B_AC;
        end
        S_B_AC: begin
          wb_q <= wb_d;
          sb_q <= sb_d;
          if ((wb_d == '0) || (wb_d >= samp_q)) begin
            t_q     <= t_q + LW'(1);
            state_q <= (t_q + LW'(1) == hi_q) ? S_PASS_END : S_B_RD;
          end else begin
            step_q  <= M_A;
            state_q <= S_B_GO;
          end
        end
        S_B_GO: begin
          state_q <= S_B_WT;
        end
        S_B_WT: begin
          if (mul_done) begin
            case (step_q)
              M_A: begin
                a_q     <= DW'(mul_p);
                step_q  <= M_B;
                state_q <= S_B_GO;
              end
              M_B: begin
                d_q     <= (a_q >= DW'(mul_p)) ? a_q - DW'(mul_p) : DW'(mul_p) - a_q;
                step_q  <= M_DEN;
                state_q <= S_B_GO;
              end
              M_DEN: begin
                den_q   <= NW'(mul_p);
                step_q  <= M_DSQ;
                state_q <= S_B_GO;
              end
              M_DSQ: begin
                dsq_q <= (2*DW)'(mul_p);
                if (!have_q) begin
                  have_q  <= 1'b1;
                  bsq_q   <= (2*DW)'(mul_p);
                  bn_q    <= den_q;
                  thr_q   <= 8'(t_q);
                  t_q     <= t_q + LW'(1);
                  state_q <= (t_q + LW'(1) == hi_q) ? S_PASS_END : S_B_RD;
                end else begin
                  step_q  <= M_LHS;
                  state_q <= S_B_GO;
                end
              end
              M_LHS: begin
                lhs_q   <= mul_p;
                step_q  <= M_RHS;
                state_q <= S_B_GO;
              end
              M_RHS: begin
                if (lhs_q > mul_p) begin
                  bsq_q <= dsq_q;
                  bn_q  <= den_q;
                  thr_q <= 8'(t_q);
                end
                t_q     <= t_q + LW'(1);
                state_q <= (t_q + LW'(1) == hi_q) ? S_PASS_END : S_B_RD;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_PASS_END: begin
          if (!pass_q) begin
            t1_q    <= thr_fin;
            pass_q  <= 1'b1;
            t_q     <= '0;
            cum_q   <= '0;
            any_q   <= 1'b0;
            tot_q   <= '0;
            state_q <= S_A_RD;
          end else begin
            active_q  <= thr_fin;
            kind_q    <= tpob_pkg::KIND_THRESH;
            thr_out_q <= thr_fin;
            first_q   <= t1_q;
            white_q   <= 1'b0;
            nos_q     <= 1'b0;
            vld_q     <= '0;
            samp_q    <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if ((state_q == S_IDLE) && queue_i.valid && (queue_i.cmd.op == tpob_pkg::OP_COMPUTE)
          && (samp_q == '0)) begin
        samp_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr;
  end

  assign result_valid_o    = valid_q;
  assign result_kind_o     = kind_q;
  assign threshold_value_o = thr_out_q;
  assign first_threshold_o = first_q;
  assign pixel_white_o     = white_q;
  assign no_samples_o      = nos_q;

  `TPOB_ASSERT_IMP(a_pop_idle, pop_o, state_q == S_IDLE, "pop outside idle")
  `TPOB_ASSERT_IMP(a_done_wait, mul_done, state_q == S_B_WT, "multiply done while not waiting")
  `TPOB_ASSERT_IMP(a_sample_inc, state_q == S_SMP_WR, samp_q != '1, "sample past saturation")

endmodule
`default_nettype wire

@@ rtl/core/two_pass_otsu_binarizer.sv @@
`default_nettype none
// Two-pass Otsu binarizer. An item is taken when start_i is high and busy_o low; a two-entry
// queue holds taken items, and busy_o rises while it is full. Results cannot be stalled: each
// one appears on the result ports for a single cycle with result_valid_o high. A sample item
// occupies the histogram engine for one read-modify-write on the one histogram RAM, and a
// classify item is answered from the idle state; odd-coordinate samples and mode 3 are
// dropped at the input. An end-of-frame item with samples runs two passes, each a sweep of
// the histogram RAM followed by a walk from the lowest toward the highest occupied level plus,
// per candidate level, up to six shift-add multiplies (four on the first candidate) on the
// single shared multiplier; the walk time dominates and depends on the histogram.
module two_pass_otsu_binarizer #(
  parameter int unsigned GRAY_LEVELS = tpob_pkg::GRAY_LEVELS,
  parameter int unsigned COUNT_WIDTH = tpob_pkg::COUNT_WIDTH,
  parameter int unsigned COORD_WIDTH = tpob_pkg::COORD_WIDTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [tpob_pkg::MODE_W-1:0] mode_i,
  input  wire logic [tpob_pkg::PIX_W-1:0]  pixel_value_i,
  input  wire logic [COORD_WIDTH-1:0]      x_pos_i,
  input  wire logic [COORD_WIDTH-1:0]      y_pos_i,
  output logic                             result_valid_o,
  output logic                             result_kind_o,
  output logic [tpob_pkg::PIX_W-1:0]       threshold_value_o,
  output logic [tpob_pkg::PIX_W-1:0]       first_threshold_o,
  output logic                             pixel_white_o,
  output logic                             no_samples_o
);

  tpob_pkg::queue_t queue;
  logic             pop;

  tpob_front #(
    .CoordWidth(COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .pixel_value_i(pixel_value_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .queue_o      (queue),
    .pop_i        (pop)
  );

  tpob_back #(
    .GrayLevels(GRAY_LEVELS),
    .CountWidth(COUNT_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .queue_i          (queue),
    .pop_o            (pop),
    .result_valid_o   (result_valid_o),
    .result_kind_o    (result_kind_o),
    .threshold_value_o(threshold_value_o),
    .first_threshold_o(first_threshold_o),
    .pixel_white_o    (pixel_white_o),
    .no_samples_o     (no_samples_o)
  );

endmodule
`default_nettype wire
